### src/b64enc_pkg.sv
// Shared types, constants and the character lookup of the base64 stream encoder.
package b64enc_pkg;

    // Position of the next byte inside its three-byte group
    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } t_phase;

    // Number of characters a job can carry
    localparam int JOB_CHARS = 4;

    // ASCII '=' used as group padding
    localparam logic [6:0] CHAR_PAD = 7'd61;

    // One classified byte: up to four characters, count minus one, last flag
    typedef struct packed {
        logic [JOB_CHARS-1:0][6:0] chars;
        logic [1:0]                cnt_m1;
        logic                      last;
    } t_job;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

    // Map a 6-bit code to its character of the standard alphabet
    function automatic logic [6:0] b64_char(input logic [5:0] code);
        logic [6:0] wide;
        wide = {1'b0, code};
        if (code < 6'd26) begin
            b64_char = wide + 7'd65;          // 'A'..'Z'
        end else if (code < 6'd52) begin
            b64_char = wide + 7'd71;          // 'a'..'z'
        end else if (code < 6'd62) begin
            b64_char = wide - 7'd4;           // '0'..'9'
        end else if (code == 6'd62) begin
            b64_char = 7'd43;                 // '+'
        end else begin
            b64_char = 7'd47;                 // '/'
        end
    endfunction

endpackage

### src/base64_stream_encoder_top.sv
// Top level of the streaming base64 encoder (standard alphabet, '=' padding).
//
//  Channel  Dir  Handshake            Payload
//  s        in   i_s_tvalid/o_s_tready i_s_tdata = in_byte[7:0], i_s_tlast = last_byte
//  m        out  o_m_tvalid/i_m_tready o_m_tdata = out_char[6:0], pad bit 7; o_m_tlast = last_char
//
// A byte is taken in the cycle it arrives whenever the job queue has room,
// so bytes may come back to back; each byte yields one to four characters.
// The output register sends one character per cycle while the receiver is ready,
// which sets the rate: on average four characters per three bytes; a byte's
// characters pass through the job queue and then the output register.
// Reset (synchronous, active low) empties the queue and restarts at a group
// boundary. A stall on the output fills the queue, and only then drops
// o_s_tready; a stalled character holds in the output register.
module base64_stream_encoder_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] in_byte
    input  logic       i_s_tlast,    // last_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,    // [6:0] out_char, [7] zero
    output logic       o_m_tlast     // last_char
);
    import b64enc_pkg::*;

    t_job    w_front_job;
    t_job    w_head_job;
    t_q_stat w_q_stat;
    t_phase  w_phase;
    logic    w_s_accept;
    logic    w_pop;
    logic [6:0] w_char;

    // Accept a request whenever the queue has a free slot
    assign o_s_tready = !w_q_stat.full;
    assign w_s_accept = i_s_tvalid && o_s_tready;

    b64enc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_s_accept),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_job    (w_front_job),
        .o_phase  (w_phase)
    );

    b64enc_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_s_accept),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_stat  (w_q_stat)
    );

    b64enc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_head_job),
        .i_job_valid (w_q_stat.valid),
        .o_pop       (w_pop),
        .i_ready     (i_m_tready),
        .o_valid     (o_m_tvalid),
        .o_char      (w_char),
        .o_last      (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, w_char};

`ifndef ASSERT_OFF
    // The final byte of a message always leaves the front at a group start
    a_last_restarts_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_accept && i_s_tlast) |=> (w_phase == PH_0))
        else $error("group phase not restarted after last byte");

    // A new character only appears when the queue held a job
    a_out_from_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_q_stat.valid))
        else $error("output valid without a queued job");

    // The queue only becomes full through a push
    a_full_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_q_stat.full) |-> $past(w_s_accept))
        else $error("queue became full without a push");
`endif

endmodule

### src/b64enc_front.sv
// Front end: track the group phase and turn each byte into a character job.
module b64enc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output b64enc_pkg::t_job  o_job,
    output b64enc_pkg::t_phase o_phase
);
    import b64enc_pkg::*;

    t_phase     r_phase, n_phase;
    logic [3:0] r_left,  n_left;

    // Next phase and leftover bits
    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        if (i_accept) begin
            case (r_phase)
                PH_1: begin
                    n_phase = PH_2;
                    n_left  = i_byte[3:0];
                end
                PH_2: begin
                    n_phase = PH_0;
                    n_left  = 4'd0;
                end
                default: begin
                    n_phase = PH_1;
                    n_left  = {2'b00, i_byte[1:0]};
                end
            endcase
            // end of message: restart at group start
            if (i_last) begin
                n_phase = PH_0;
                n_left  = 4'd0;
            end
        end
    end

    // Job contents for the current byte
    always_comb begin
        o_job.chars  = {JOB_CHARS{CHAR_PAD}};
        o_job.cnt_m1 = 2'd0;
        o_job.last   = i_last;
        case (r_phase)
            PH_1: begin
                o_job.chars[0] = b64_char({r_left[1:0], i_byte[7:4]});
                o_job.chars[1] = b64_char({i_byte[3:0], 2'b00});
                o_job.cnt_m1   = i_last ? 2'd2 : 2'd0;
            end
            PH_2: begin
                o_job.chars[0] = b64_char({r_left, i_byte[7:6]});
                o_job.chars[1] = b64_char(i_byte[5:0]);
                o_job.cnt_m1   = 2'd1;
            end
            default: begin
                o_job.chars[0] = b64_char(i_byte[7:2]);
                o_job.chars[1] = b64_char({i_byte[1:0], 4'b0000});
                o_job.cnt_m1   = i_last ? 2'd3 : 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_0;
            r_left  <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    assign o_phase = r_phase;

endmodule

### src/b64enc_queue.sv
// Short job queue between the front and the back.
module b64enc_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  b64enc_pkg::t_job    i_job,
    input  logic                i_pop,
    output b64enc_pkg::t_job    o_job,
    output b64enc_pkg::t_q_stat o_stat
);
    import b64enc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_job        = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.valid = (r_cnt != '0);

endmodule

### src/b64enc_back.sv
// Back end: one character of the head job per ready cycle into output register.
module b64enc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  b64enc_pkg::t_job i_job,
    input  logic             i_job_valid,
    output logic             o_pop,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [6:0]       o_char,
    output logic             o_last
);
    import b64enc_pkg::*;

    logic       r_valid;
    logic [6:0] r_char;
    logic       r_last;
    logic [1:0] r_idx, n_idx;
    logic       w_load;
    logic       w_end;

    assign w_load = i_job_valid && (!r_valid || i_ready);
    assign w_end  = (r_idx == i_job.cnt_m1);
    assign o_pop  = w_load && w_end;

    always_comb begin
        n_idx = r_idx;
        if (w_load) begin
            n_idx = w_end ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_idx <= n_idx;
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_char <= i_job.chars[r_idx];
            r_last <= i_job.last && w_end;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

### bench/tb_top.sv
// Self-checking bench for the streaming base64 encoder: byte requests in, checked characters out.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import b64enc_pkg::*;

    // Standard alphabet, first character in the top byte
    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // Cycles without any accepted request before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // Cycles to keep watching the output once nothing is expected
    localparam int DRAIN_CYCLES = 20;
    // Random part size, in source bytes
    localparam int RANDOM_BYTES = 150;
    // Window with no idling on either side
    localparam int BURST_START = 150;
    localparam int BURST_END = 300;
    // Long receiver hold-off: start cycle and length
    localparam int HOLDOFF_START = 60;
    localparam int HOLDOFF_LEN = 80;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_src_byte;

    typedef struct {
        logic [6:0] ch;
        logic       last;
    } t_b64_char;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;    // [7:0] in_byte
    logic       i_s_tlast;    // last_byte
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;    // [6:0] out_char, [7] zero
    logic       o_m_tlast;    // last_char

    t_src_byte  byte_queue[$];      // source bytes not yet offered
    t_b64_char  pending_chars[$];   // characters predicted but not yet seen

    // Encoder state mirror
    t_phase     enc_phase;
    logic [3:0] enc_leftover;

    int         cyc;
    int         mismatch_count;
    int         quiet_cycles;
    int         holdoff_left;
    bit         s_taken;            // byte request accepted at the last rising edge

    base64_stream_encoder_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Map a 6-bit code to its ASCII character
    function automatic logic [6:0] b64_lookup(input logic [5:0] code);
        return B64_ALPHABET[8*(63 - int'(code)) +: 7];
    endfunction

    function automatic void push_char(input logic [6:0] ch, input logic last);
        t_b64_char c;
        c.ch = ch;
        c.last = last;
        pending_chars.push_back(c);
    endfunction

    // Advance the encoder mirror by one byte and queue the characters it yields
    function automatic void encode_byte(input logic [7:0] b, input logic fin);
        case (enc_phase)
            PH_1: begin
                push_char(b64_lookup({enc_leftover[1:0], b[7:4]}), 1'b0);
                if (fin) begin
                    push_char(b64_lookup({b[3:0], 2'b00}), 1'b0);
                    push_char(CHAR_PAD, 1'b1);
                end
                enc_leftover = b[3:0];
                enc_phase = PH_2;
            end
            PH_2: begin
                push_char(b64_lookup({enc_leftover, b[7:6]}), 1'b0);
                push_char(b64_lookup(b[5:0]), fin);
                enc_leftover = 4'd0;
                enc_phase = PH_0;
            end
            default: begin
                // Phase 0, and the unused phase value treated the same way
                push_char(b64_lookup(b[7:2]), 1'b0);
                if (fin) begin
                    push_char(b64_lookup({b[1:0], 4'b0000}), 1'b0);
                    push_char(CHAR_PAD, 1'b0);
                    push_char(CHAR_PAD, 1'b1);
                end
                enc_leftover = {2'b00, b[1:0]};
                enc_phase = PH_1;
            end
        endcase
        // End of message: restart at a group boundary
        if (fin) begin
            enc_phase = PH_0;
            enc_leftover = 4'd0;
        end
    endfunction

    function automatic void add_byte(input logic [7:0] data, input logic last);
        t_src_byte s;
        s.data = data;
        s.last = last;
        byte_queue.push_back(s);
    endfunction

    // Rising edge: record accepted requests on both sides, predict and compare
    always @(posedge i_clk) begin
        t_b64_char exp_c;
        s_taken = 1'b0;
        cyc = cyc + 1;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                s_taken = 1'b1;
                encode_byte(i_s_tdata, i_s_tlast);
            end
            if (o_m_tvalid && i_m_tready) begin
                if (pending_chars.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    $display("%0t: unexpected char: expected none, actual tdata=%h last=%b",
                             $time, o_m_tdata, o_m_tlast);
                end else begin
                    exp_c = pending_chars.pop_front();
                    if (o_m_tdata !== {1'b0, exp_c.ch}) begin
                        mismatch_count = mismatch_count + 1;
                        $display("%0t: out_char mismatch: expected %h, actual %h",
                                 $time, {1'b0, exp_c.ch}, o_m_tdata);
                    end
                    if (o_m_tlast !== exp_c.last) begin
                        mismatch_count = mismatch_count + 1;
                        $display("%0t: last_char mismatch: expected %b, actual %b",
                                 $time, exp_c.last, o_m_tlast);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no request moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Byte driver: hold a request until taken, then advance or idle at random
    always @(negedge i_clk) begin
        bit no_idle;
        t_src_byte s;
        // Keep offering during the burst window and across the receiver hold-off
        no_idle = (cyc >= BURST_START && cyc < BURST_END) ||
                  (cyc >= HOLDOFF_START - 5 && cyc < HOLDOFF_START + HOLDOFF_LEN + 5);
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && !s_taken) begin
            // hold the current request
        end else if (byte_queue.size() != 0 && (no_idle || $urandom_range(99) >= 34)) begin
            s = byte_queue.pop_front();
            i_s_tvalid <= 1'b1;
            i_s_tdata <= s.data;
            i_s_tlast <= s.last;
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    // Receiver: random back-pressure, ready in the burst window, one long hold-off to fill the block
    always @(negedge i_clk) begin
        if (cyc == HOLDOFF_START) begin
            holdoff_left = HOLDOFF_LEN;
        end
        if (holdoff_left > 0) begin
            holdoff_left = holdoff_left - 1;
            i_m_tready <= 1'b0;
        end else if (cyc >= BURST_START && cyc < BURST_END) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= 34);
        end
    end

    initial begin
        int total;
        int len;
        logic [7:0] b;

        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = 8'd0;
        i_s_tlast = 1'b0;
        i_m_tready = 1'b0;
        cyc = 0;
        mismatch_count = 0;
        quiet_cycles = 0;
        holdoff_left = 0;
        s_taken = 1'b0;
        enc_phase = PH_0;
        enc_leftover = 4'd0;

        // Directed: one-byte messages at the extremes (flush from phase 0)
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        // Two-byte messages (flush from phase 1)
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b1);
        // Full groups: all ones, all zeros, and the '+' characters
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b1);
        add_byte(8'hFB, 1'b0);
        add_byte(8'hEF, 1'b0);
        add_byte(8'hBE, 1'b1);
        // Group followed by a partial group, both pad lengths
        add_byte(8'h4D, 1'b0);
        add_byte(8'h61, 1'b0);
        add_byte(8'h6E, 1'b0);
        add_byte(8'h4D, 1'b1);
        add_byte(8'h12, 1'b0);
        add_byte(8'h34, 1'b0);
        add_byte(8'h56, 1'b0);
        add_byte(8'h78, 1'b0);
        add_byte(8'hAB, 1'b1);

        // Random messages: mostly short, a few long, each closed by its last byte
        total = 0;
        while (total < RANDOM_BYTES) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(8, 1);
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(7))
                    0: b = 8'h00;
                    1: b = 8'hFF;
                    default: b = 8'($urandom_range(255));
                endcase
                add_byte(b, k == len - 1);
            end
            total = total + len;
        end

        // Release reset on a falling clock edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Wait for every byte request to be taken, then for every character
        while (byte_queue.size() != 0 || i_s_tvalid) @(posedge i_clk);
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_chars.size() != 0) begin
            mismatch_count = mismatch_count + 1;
            $display("%0t: leftover chars: expected 0, actual %0d",
                     $time, pending_chars.size());
        end
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
